### hw/rtl/qtt_pkg.sv
// Shared types, token codes and keyword tables for the query text tokenizer.
`timescale 1ns / 1ps

package qtt_pkg;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  token_char;
        logic        token_last;
        logic [30:0] number_value;
        logic        number_overflow;
        logic        word_truncated;
    } out_word_t;

    typedef enum logic [2:0] {
        PEND_NONE,
        PEND_WORD,
        PEND_NUM,
        PEND_GT,
        PEND_LT
    } pend_t;

    localparam logic [3:0] KIND_SELECT = 4'd0;
    localparam logic [3:0] KIND_FROM   = 4'd1;
    localparam logic [3:0] KIND_WHERE  = 4'd2;
    localparam logic [3:0] KIND_OR     = 4'd3;
    localparam logic [3:0] KIND_NAME   = 4'd4;
    localparam logic [3:0] KIND_NUMBER = 4'd5;
    localparam logic [3:0] KIND_GT     = 4'd6;
    localparam logic [3:0] KIND_LT     = 4'd7;
    localparam logic [3:0] KIND_EQ     = 4'd8;
    localparam logic [3:0] KIND_GE     = 4'd9;
    localparam logic [3:0] KIND_LE     = 4'd10;
    localparam logic [3:0] KIND_OPEN   = 4'd11;
    localparam logic [3:0] KIND_CLOSE  = 4'd12;
    localparam logic [3:0] KIND_END    = 4'd13;

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] KEY_SELECT = 2'd0;
    localparam logic [1:0] KEY_FROM   = 2'd1;
    localparam logic [1:0] KEY_WHERE  = 2'd2;
    localparam logic [1:0] KEY_OR     = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load_in;
        logic       store;
        logic       add_digit;
        logic       set_pend;
        pend_t      pend_value;
        logic       clear_token;
        logic       emit_single;
        logic [3:0] single_kind;
        logic       flush_start;
        logic       flush_emit;
    } qtt_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        pend_t pend;
        logic  eot;
        logic  c_letter;
        logic  c_digit;
        logic  c_under;
        logic  c_gt;
        logic  c_lt;
        logic  c_eq;
        logic  c_open;
        logic  c_close;
        logic  flush_last;
        logic  out_free;
    } qtt_status_t;

    // Upper-case keyword characters; zero past the end of a keyword.
    function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] pos);
        logic [47:0] s;
        logic [7:0]  c;
        begin
            case (kw)
                KEY_SELECT: s = "SELECT";
                KEY_FROM:   s = {"FROM", 16'h0000};
                KEY_WHERE:  s = {"WHERE", 8'h00};
                KEY_OR:     s = {"OR", 32'h0000_0000};
                default:    s = 48'h0;
            endcase
            case (pos)
                3'd0:    c = s[47:40];
                3'd1:    c = s[39:32];
                3'd2:    c = s[31:24];
                3'd3:    c = s[23:16];
                3'd4:    c = s[15:8];
                3'd5:    c = s[7:0];
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] kw);
        logic [2:0] n;
        begin
            case (kw)
                KEY_SELECT: n = 3'd6;
                KEY_FROM:   n = 3'd4;
                KEY_WHERE:  n = 3'd5;
                KEY_OR:     n = 3'd2;
                default:    n = 3'd0;
            endcase
            return n;
        end
    endfunction

endpackage

### hw/rtl/qtt_ctrl.sv
// Tokenizer controller: sequences accept, classify, flush and emit steps.
`timescale 1ns / 1ps

module qtt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_stall,
    input  qtt_pkg::qtt_status_t status,
    output qtt_pkg::qtt_cmd_t    cmd
);
    import qtt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_FL_READ,
        S_FL_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic word_cont;
    logic num_cont;

    assign text_stall = (state_reg != S_IDLE);
    assign word_cont  = !status.eot && (status.c_letter || status.c_digit || status.c_under);
    assign num_cont   = !status.eot && status.c_digit;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.pend_value = PEND_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (text_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_STEP;
                end
            end
            S_STEP:
            begin
                case (status.pend)
                    PEND_GT, PEND_LT:
                    begin
                        // Operator either merges with '=' or goes out alone;
                        // in the second case the held word is looked at again.
                        if (status.out_free)
                        begin
                            cmd.emit_single = 1'b1;
                            cmd.clear_token = 1'b1;
                            if (!status.eot && status.c_eq)
                            begin
                                cmd.single_kind = (status.pend == PEND_GT) ? KIND_GE : KIND_LE;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                cmd.single_kind = (status.pend == PEND_GT) ? KIND_GT : KIND_LT;
                            end
                        end
                    end
                    PEND_WORD:
                    begin
                        if (word_cont)
                        begin
                            cmd.store  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.flush_start = 1'b1;
                            state_next      = S_FL_READ;
                        end
                    end
                    PEND_NUM:
                    begin
                        if (num_cont)
                        begin
                            cmd.store     = 1'b1;
                            cmd.add_digit = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            cmd.flush_start = 1'b1;
                            state_next      = S_FL_READ;
                        end
                    end
                    default:
                    begin
                        if (status.eot)
                        begin
                            if (status.out_free)
                            begin
                                cmd.emit_single = 1'b1;
                                cmd.single_kind = KIND_END;
                                state_next      = S_IDLE;
                            end
                        end
                        else if (status.c_letter)
                        begin
                            cmd.store      = 1'b1;
                            cmd.set_pend   = 1'b1;
                            cmd.pend_value = PEND_WORD;
                            state_next     = S_IDLE;
                        end
                        else if (status.c_digit)
                        begin
                            cmd.store      = 1'b1;
                            cmd.add_digit  = 1'b1;
                            cmd.set_pend   = 1'b1;
                            cmd.pend_value = PEND_NUM;
                            state_next     = S_IDLE;
                        end
                        else if (status.c_gt || status.c_lt)
                        begin
                            cmd.set_pend   = 1'b1;
                            cmd.pend_value = status.c_gt ? PEND_GT : PEND_LT;
                            state_next     = S_IDLE;
                        end
                        else if (status.c_eq || status.c_open || status.c_close)
                        begin
                            if (status.out_free)
                            begin
                                cmd.emit_single = 1'b1;
                                cmd.single_kind = status.c_eq ? KIND_EQ :
                                                  (status.c_open ? KIND_OPEN : KIND_CLOSE);
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_FL_READ:
            begin
                // Buffer read data lands in its register this cycle.
                state_next = S_FL_EMIT;
            end
            S_FL_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.flush_emit = 1'b1;
                    if (status.flush_last)
                    begin
                        cmd.clear_token = 1'b1;
                        state_next      = S_STEP;
                    end
                    else
                    begin
                        state_next = S_FL_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/qtt_datapath.sv
// Tokenizer datapath: held word, character buffer, number accumulator, output register.
`timescale 1ns / 1ps

module qtt_datapath #(
    parameter int WORD_CAPACITY = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qtt_pkg::in_word_t    text_word,
    input  qtt_pkg::qtt_cmd_t    cmd,
    output qtt_pkg::qtt_status_t status,
    output logic                 token_valid,
    input  logic                 token_stall,
    output qtt_pkg::out_word_t   token_word
);
    import qtt_pkg::*;

    localparam int LW = $clog2(WORD_CAPACITY + 1);
    localparam int AW = $clog2(WORD_CAPACITY);
    localparam logic [LW-1:0] CAP_L = LW'(WORD_CAPACITY);

    logic [7:0]    mem [WORD_CAPACITY];
    logic [7:0]    rd_data_reg;

    in_word_t      held_reg;
    logic [LW-1:0] length_reg, length_next;
    pend_t         pend_reg, pend_next;
    logic [30:0]   acc_reg, acc_next;
    logic          ovf_reg, ovf_next;
    logic          trunc_reg, trunc_next;
    logic [3:0]    kw_ok_reg, kw_ok_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    out_word_t     out_reg, out_next;

    logic [7:0]    c;
    logic [7:0]    c_up;
    logic          wr_en;
    logic [34:0]   acc_x10;
    logic [3:0]    flush_kind;
    logic          is_num;

    assign c    = held_reg.text_char;
    assign c_up = (c >= "a" && c <= "z") ? (c - 8'd32) : c;

    always_comb
    begin
        status            = '0;
        status.pend       = pend_reg;
        status.eot        = held_reg.end_of_text;
        status.c_letter   = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        status.c_digit    = (c >= "0" && c <= "9");
        status.c_under    = (c == "_");
        status.c_gt       = (c == ">");
        status.c_lt       = (c == "<");
        status.c_eq       = (c == "=");
        status.c_open     = (c == "(");
        status.c_close    = (c == ")");
        status.flush_last = ((LW'(idx_reg) + LW'(1)) == length_reg);
        status.out_free   = !out_valid_reg || !token_stall;
    end

    assign is_num = (pend_reg == PEND_NUM);

    always_comb
    begin
        if (is_num)
            flush_kind = KIND_NUMBER;
        else if (!trunc_reg && kw_ok_reg[KEY_SELECT] && length_reg == LW'(kw_len(KEY_SELECT)))
            flush_kind = KIND_SELECT;
        else if (!trunc_reg && kw_ok_reg[KEY_FROM] && length_reg == LW'(kw_len(KEY_FROM)))
            flush_kind = KIND_FROM;
        else if (!trunc_reg && kw_ok_reg[KEY_WHERE] && length_reg == LW'(kw_len(KEY_WHERE)))
            flush_kind = KIND_WHERE;
        else if (!trunc_reg && kw_ok_reg[KEY_OR] && length_reg == LW'(kw_len(KEY_OR)))
            flush_kind = KIND_OR;
        else
            flush_kind = KIND_NAME;
    end

    // acc * 10 + digit as two shifts and adds
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {31'b0, c[3:0] - 4'd0};

    always_comb
    begin
        length_next = length_reg;
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        trunc_next  = trunc_reg;
        kw_ok_next  = kw_ok_reg;
        idx_next    = idx_reg;
        wr_en       = 1'b0;

        if (cmd.clear_token)
        begin
            length_next = '0;
            pend_next   = PEND_NONE;
            acc_next    = '0;
            ovf_next    = 1'b0;
            trunc_next  = 1'b0;
            kw_ok_next  = 4'hF;
        end
        if (cmd.set_pend)
            pend_next = cmd.pend_value;
        if (cmd.store)
        begin
            if (length_reg != CAP_L)
            begin
                wr_en       = 1'b1;
                length_next = length_reg + LW'(1);
            end
            else
            begin
                trunc_next = 1'b1;
            end
            // Keyword match tracked as characters arrive; past eight chars
            // the length check rules every keyword out anyway.
            if (int'(length_reg) < 8)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (c_up != kw_char(2'(k), length_reg[2:0]))
                        kw_ok_next[k] = 1'b0;
                end
            end
            if (cmd.add_digit)
            begin
                if (acc_x10 > {4'b0, VALUE_MAX})
                begin
                    acc_next = VALUE_MAX;
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_x10[30:0];
                end
            end
        end
        if (cmd.flush_start)
            idx_next = '0;
        else if (cmd.flush_emit)
            idx_next = idx_reg + AW'(1);
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (cmd.emit_single)
        begin
            out_next            = '0;
            out_next.token_kind = cmd.single_kind;
            out_next.token_last = 1'b1;
            out_valid_next      = 1'b1;
        end
        else if (cmd.flush_emit)
        begin
            out_next.token_kind      = flush_kind;
            out_next.token_char      = rd_data_reg;
            out_next.token_last      = status.flush_last;
            out_next.number_value    = is_num ? acc_reg : 31'd0;
            out_next.number_overflow = is_num ? ovf_reg : 1'b0;
            out_next.word_truncated  = trunc_reg;
            out_valid_next           = 1'b1;
        end
        else if (!token_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[length_reg[AW-1:0]] <= c;
        rd_data_reg <= mem[idx_reg];
        if (cmd.load_in)
            held_reg <= text_word;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            pend_reg      <= PEND_NONE;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            trunc_reg     <= 1'b0;
            kw_ok_reg     <= 4'hF;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            pend_reg      <= pend_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            trunc_reg     <= trunc_next;
            kw_ok_reg     <= kw_ok_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign token_valid = out_valid_reg;
    assign token_word  = out_reg;

endmodule

### hw/rtl/query_text_tokenizer.sv
// Top level of the query text tokenizer: controller plus datapath.
`timescale 1ns / 1ps

// Usage:
//   text channel (text_valid / text_stall / text_word) takes one word per
//   accepted cycle: a text byte, or the end marker, which flushes any
//   pending token and then yields an end token.
//   token channel (token_valid / token_stall / token_word) gives one word
//   per token character for words and numbers, one word for operators,
//   parentheses and end. token_last marks the final word of each token.
// Timing:
//   A text word is accepted and then classified, also when it gives a
//   single-word token. Closing a held > or < that does not merge with = adds
//   another classify step; a flush of buffered characters adds a registered
//   buffer read and an emit per character, then the text word is classified again.
//   token_valid rises the cycle after a token word is formed. text_stall
//   is high whenever the controller is not waiting for input.
// Stall: a stalled token word holds in the output register; the controller
//   waits on it and keeps text_stall high.
// Reset: no token pending, buffer length zero; buffer contents need no
//   clearing since only characters of the current token are read.
module query_text_tokenizer #(
    parameter int WORD_CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_stall,
    input  qtt_pkg::in_word_t  text_word,
    output logic               token_valid,
    input  logic               token_stall,
    output qtt_pkg::out_word_t token_word
);
    import qtt_pkg::*;

    qtt_cmd_t    cmd;
    qtt_status_t status;

    qtt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .status     (status),
        .cmd        (cmd)
    );

    qtt_datapath #(
        .WORD_CAPACITY (WORD_CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_word   (text_word),
        .cmd         (cmd),
        .status      (status),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_word  (token_word)
    );

endmodule
